@@ design/hbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the hierarchical bitset successor block.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int WORD_BITS = 64;
  localparam int LEAVES    = 64;
  localparam int CAP       = LEAVES * WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LEAF_W    = $clog2(LEAVES);
  localparam int SLOT_W    = LEAF_W + BIT_W;

  localparam logic [SLOT_W-1:0]    N_MAX      = SLOT_W'(CAP - 2);
  localparam logic [SLOT_W-1:0]    SIZE_RESET = SLOT_W'(4094);
  localparam logic [WORD_BITS-1:0] WORD_ONE   = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] WORD_ALL   = '1;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_INSERT   = 3'd0;
  localparam mode_t MODE_ERASE    = 3'd1;
  localparam mode_t MODE_CONTAINS = 3'd2;
  localparam mode_t MODE_NEXT     = 3'd3;
  localparam mode_t MODE_PREV     = 3'd4;
  localparam mode_t MODE_CLEAR    = 3'd5;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_INIT_LO,
    ST_INIT_HI,
    ST_IDLE,
    ST_LEAF,
    ST_SUMM,
    ST_LEAF2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              nz;
    logic [BIT_W-1:0]  idx;
  } scan_res_t;

endpackage

@@ design/hbs_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_scan
// Bit scan unit: lowest or highest set bit of one word, plus a non-zero flag.
// ----------------------------------------------------------------------------
module hbs_scan
  import hbs_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  logic                 dir_down,
  output scan_res_t            res
);

  always_comb begin
    res.nz  = |word;
    res.idx = '0;
    if (dir_down) begin
      // last hit wins: highest set bit
      for (int k = 0; k < WORD_BITS; k++) begin
        if (word[k]) res.idx = BIT_W'(k);
      end
    end else begin
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
        if (word[k]) res.idx = BIT_W'(k);
      end
    end
  end

endmodule

@@ design/hierarchical_bitset_successor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_bitset_successor
// Two-level 64-ary bit tree set with insert, erase, contains, find-next,
// find-previous and clear, one operation per input beat.
// ----------------------------------------------------------------------------
// One input beat at a time is worked on; in_tready is low meanwhile. Insert,
// erase and contains go from accept to result through a leaf word read, one
// evaluation and a result load; find-next and find-previous take longer when
// the answer does not lie in the start leaf word but needs the summary word
// and a second leaf word, since both levels go through the one bit-scan unit
// and the single read port of the leaf word memory. An index out of range or
// an unused mode goes straight to the result load, as no leaf word is read.
// After reset the tree is built in a pass (drop all leaf words, then write the
// two sentinel slots) before the first beat is taken. A new set_size is used
// from the next clear on. A result may wait in the output register while the
// next beat is accepted.
// ----------------------------------------------------------------------------
module hierarchical_bitset_successor
  import hbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,   // set_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [2:0] mode, [14:3] index, [15] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // [0] found, [12:1] position, [15:13] zero
);

  state_t               state_r, state_nxt;
  mode_t                mode_r, mode_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SLOT_W-1:0]    n_r, n_nxt;
  logic [SLOT_W-1:0]    set_size_r;
  logic [LEAVES-1:0]    summ_r, summ_nxt;
  logic [LEAVES-1:0]    valid_r, valid_nxt;
  logic [LEAF_W-1:0]    leaf2_r, leaf2_nxt;
  logic                 clr_reply_r, clr_reply_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [SLOT_W-1:0]    res_pos_r, res_pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [SLOT_W-1:0]    out_pos_r, out_pos_nxt;

  logic [WORD_BITS-1:0] mem [LEAVES];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rd_ok_r;
  logic                 mem_we, mem_re;
  logic [LEAF_W-1:0]    mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [WORD_BITS-1:0] scan_word;
  logic                 scan_down;
  scan_res_t            scan;

  mode_t                in_mode;
  logic [SLOT_W-1:0]    in_index, in_slot;
  logic                 in_ok;
  logic [WORD_BITS-1:0] w, bit_mask, erased;
  logic [LEAF_W-1:0]    leaf;
  logic [BIT_W-1:0]     lo;
  logic [SLOT_W-1:0]    hi_slot, cand_slot;
  logic                 cand_ok;

  assign in_mode   = in_tdata[2:0];
  assign in_index  = in_tdata[14:3];
  assign in_slot   = in_index + SLOT_W'(1);
  assign in_tready = (state_r == ST_IDLE);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_pos_r, out_found_r};

  assign leaf     = slot_r[SLOT_W-1:BIT_W];
  assign lo       = slot_r[BIT_W-1:0];
  assign w        = rd_ok_r ? rdata_r : '0;
  assign bit_mask = WORD_ONE << lo;
  assign erased   = w & ~bit_mask;
  assign hi_slot  = n_r + SLOT_W'(1);
  assign scan_down = (mode_r == MODE_PREV);

  hbs_scan u_scan (
    .word     (scan_word),
    .dir_down (scan_down),
    .res      (scan)
  );

  // candidate slot of a find, from whichever word the scan unit looks at
  always_comb begin
    if (state_r == ST_LEAF2) cand_slot = {leaf2_r, scan.idx};
    else                     cand_slot = {leaf, scan.idx};
    cand_ok = (cand_slot != '0) && (cand_slot <= n_r);
  end

  // scan unit input per step
  always_comb begin
    unique case (state_r)
      ST_LEAF: begin
        if (scan_down) scan_word = w & (WORD_ALL >> ~lo);
        else           scan_word = w & (WORD_ALL << lo);
      end
      ST_SUMM: begin
        if (scan_down) scan_word = summ_r & ((WORD_ALL >> ~leaf) >> 1);
        else           scan_word = summ_r & ((WORD_ALL << leaf) << 1);
      end
      ST_LEAF2: scan_word = w;
      default:  scan_word = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    slot_nxt      = slot_r;
    n_nxt         = n_r;
    summ_nxt      = summ_r;
    valid_nxt     = valid_r;
    leaf2_nxt     = leaf2_r;
    clr_reply_nxt = clr_reply_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    mem_we        = 1'b0;
    mem_waddr     = leaf;
    mem_wdata     = w;
    mem_re        = 1'b0;
    mem_raddr     = in_slot[SLOT_W-1:BIT_W];
    in_ok         = 1'b0;

    unique case (state_r)
      ST_CLR: begin
        n_nxt     = (set_size_r > N_MAX) ? N_MAX : set_size_r;
        summ_nxt  = '0;
        valid_nxt = '0;
        state_nxt = ST_INIT_LO;
      end
      ST_INIT_LO: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = WORD_ONE;
        if (hi_slot[SLOT_W-1:BIT_W] == '0) begin
          mem_wdata = WORD_ONE | (WORD_ONE << hi_slot[BIT_W-1:0]);
        end
        summ_nxt  = summ_r | WORD_ONE | (WORD_ONE << hi_slot[SLOT_W-1:BIT_W]);
        state_nxt = ST_INIT_HI;
      end
      ST_INIT_HI: begin
        if (hi_slot[SLOT_W-1:BIT_W] != '0) begin
          mem_we    = 1'b1;
          mem_waddr = hi_slot[SLOT_W-1:BIT_W];
          mem_wdata = WORD_ONE << hi_slot[BIT_W-1:0];
        end
        state_nxt     = clr_reply_r ? ST_DONE : ST_IDLE;
        clr_reply_nxt = 1'b0;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt      = in_mode;
          slot_nxt      = in_slot;
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          if (in_mode == MODE_NEXT) in_ok = (in_index <= n_r);
          else                      in_ok = (in_index < n_r);
          if (in_mode == MODE_CLEAR) begin
            clr_reply_nxt = 1'b1;
            state_nxt     = ST_CLR;
          end else if (in_ok && (in_mode <= MODE_PREV)) begin
            mem_re    = 1'b1;
            state_nxt = ST_LEAF;
          end else begin
            if ((in_mode == MODE_NEXT) || (in_mode == MODE_PREV)) res_pos_nxt = n_r;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_LEAF: begin
        state_nxt = ST_DONE;
        unique case (mode_r)
          MODE_INSERT: begin
            if (!w[lo]) begin
              mem_we        = 1'b1;
              mem_wdata     = w | bit_mask;
              summ_nxt      = summ_r | (WORD_ONE << leaf);
              res_found_nxt = 1'b1;
            end
          end
          MODE_ERASE: begin
            if (w[lo]) begin
              mem_we        = 1'b1;
              mem_wdata     = erased;
              if (erased == '0) summ_nxt = summ_r & ~(WORD_ONE << leaf);
              res_found_nxt = 1'b1;
            end
          end
          MODE_CONTAINS: res_found_nxt = w[lo];
          MODE_NEXT, MODE_PREV: begin
            if (scan.nz) begin
              res_found_nxt = cand_ok;
              res_pos_nxt   = cand_ok ? cand_slot - SLOT_W'(1) : n_r;
            end else begin
              state_nxt = ST_SUMM;
            end
          end
          default: ;
        endcase
      end
      ST_SUMM: begin
        if (scan.nz) begin
          leaf2_nxt = scan.idx;
          mem_re    = 1'b1;
          mem_raddr = scan.idx;
          state_nxt = ST_LEAF2;
        end else begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = n_r;
          state_nxt     = ST_DONE;
        end
      end
      ST_LEAF2: begin
        res_found_nxt = cand_ok;
        res_pos_nxt   = cand_ok ? cand_slot - SLOT_W'(1) : n_r;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase

    if (mem_we) valid_nxt[mem_waddr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      n_r         <= N_MAX;
      set_size_r  <= SIZE_RESET;
      summ_r      <= '0;
      valid_r     <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      summ_r      <= summ_nxt;
      valid_r     <= valid_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) set_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    slot_r      <= slot_nxt;
    leaf2_r     <= leaf2_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  // leaf word memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
      rd_ok_r <= valid_r[mem_raddr];
    end
  end

`ifndef NO_ASSERTIONS
  a_sentinel_low: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> summ_r[0])
    else $error("low sentinel leaf word not marked in summary");

  a_leaf2_written: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEAF2) |-> rd_ok_r)
    else $error("summary pointed at a leaf word never written");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != ST_IDLE && state_r != ST_DONE))
    else $error("leaf word write outside an operation");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_tready) |=> (state_r == ST_DONE))
    else $error("result dropped while output register busy");

  a_size_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= N_MAX)
    else $error("active size above capacity");
`endif

endmodule

@@ test/tb_hierarchical_bitset_successor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hierarchical_bitset_successor
// Self-checking bench for the two-level bit tree set. A short directed table
// covers reset state, range edges, every mode and the no-neighbour cases; then
// random operations are run over a series of set sizes, each checked against
// a behavioural copy of the tree, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_hierarchical_bitset_successor
  import hbs_pkg::*;
();

  localparam mode_t MODE_SPARE6 = 3'd6;
  localparam mode_t MODE_SPARE7 = 3'd7;

  localparam int TARGET_OPS = 850;
  localparam int QUIET_OPS  = 780;
  localparam int PHASE_OPS  = 60;
  localparam int PHASE_TRY  = 140;
  localparam int HOLD_LEN   = 120;

  typedef struct packed {
    logic        found;
    logic [11:0] pos;
  } set_answer_t;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] index;
    logic        typed;
    logic        found;
    logic [11:0] pos;
  } dir_row_t;

  // Reset state: n = 4094, set empty.
  localparam int DIR_N = 28;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{MODE_CONTAINS, 12'd0,    1'b1, 1'b0, 12'd0},
    '{MODE_NEXT,     12'd0,    1'b1, 1'b0, 12'd4094},
    '{MODE_PREV,     12'd4093, 1'b1, 1'b0, 12'd4094},
    '{MODE_INSERT,   12'd0,    1'b1, 1'b1, 12'd0},
    '{MODE_INSERT,   12'd0,    1'b1, 1'b0, 12'd0},
    '{MODE_INSERT,   12'd4093, 1'b1, 1'b1, 12'd0},
    '{MODE_INSERT,   12'd4094, 1'b1, 1'b0, 12'd0},
    '{MODE_INSERT,   12'd4095, 1'b1, 1'b0, 12'd0},
    '{MODE_CONTAINS, 12'd4093, 1'b1, 1'b1, 12'd0},
    '{MODE_NEXT,     12'd1,    1'b1, 1'b1, 12'd4093},
    '{MODE_NEXT,     12'd4094, 1'b1, 1'b0, 12'd4094},
    '{MODE_NEXT,     12'd4095, 1'b1, 1'b0, 12'd4094},
    '{MODE_PREV,     12'd4092, 1'b1, 1'b1, 12'd0},
    '{MODE_PREV,     12'd4094, 1'b1, 1'b0, 12'd4094},
    '{MODE_PREV,     12'd0,    1'b1, 1'b1, 12'd0},
    '{MODE_INSERT,   12'd63,   1'b0, 1'b0, 12'd0},
    '{MODE_INSERT,   12'd64,   1'b0, 1'b0, 12'd0},
    '{MODE_NEXT,     12'd1,    1'b0, 1'b0, 12'd0},
    '{MODE_PREV,     12'd62,   1'b0, 1'b0, 12'd0},
    '{MODE_PREV,     12'd4092, 1'b0, 1'b0, 12'd0},
    '{MODE_ERASE,    12'd0,    1'b1, 1'b1, 12'd0},
    '{MODE_ERASE,    12'd0,    1'b1, 1'b0, 12'd0},
    '{MODE_ERASE,    12'd4095, 1'b1, 1'b0, 12'd0},
    '{MODE_PREV,     12'd62,   1'b1, 1'b0, 12'd4094},
    '{MODE_SPARE6,   12'd4095, 1'b1, 1'b0, 12'd0},
    '{MODE_SPARE7,   12'd0,    1'b1, 1'b0, 12'd0},
    '{MODE_CLEAR,    12'd0,    1'b1, 1'b0, 12'd0},
    '{MODE_CONTAINS, 12'd63,   1'b1, 1'b0, 12'd0}
  };

  localparam int SIZE_PLAN_N = 10;
  localparam int SIZE_PLAN [SIZE_PLAN_N] = '{0, 1, 2, 63, 64, 65, 4095, 127, 1000, 4094};

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;      // [2:0] mode, [14:3] index, [15] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;     // [0] found, [12:1] position, [15:13] zero

  hierarchical_bitset_successor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // Shadow copy of the tree
  logic [WORD_BITS-1:0] shadow_leaf [LEAVES];
  logic [WORD_BITS-1:0] shadow_summ;
  logic [11:0]          shadow_size;
  logic [11:0]          live_n;

  set_answer_t pending_answers [$];
  set_answer_t head_answer;

  int  fail_count   = 0;
  int  ops_sent     = 0;
  int  results_seen = 0;
  int  size_count   = 0;
  bit  tx_idle_on   = 1'b1;
  bit  rx_idle_on   = 1'b1;
  bit  hold_pending = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int low_bit(logic [WORD_BITS-1:0] w);
    for (int k = 0; k < WORD_BITS; k++) if (w[k]) return k;
    return 0;
  endfunction

  function automatic int high_bit(logic [WORD_BITS-1:0] w);
    for (int k = WORD_BITS - 1; k >= 0; k--) if (w[k]) return k;
    return 0;
  endfunction

  function automatic void slot_mark(int s);
    shadow_leaf[s / WORD_BITS][s % WORD_BITS] = 1'b1;
    shadow_summ[s / WORD_BITS] = 1'b1;
  endfunction

  function automatic void slot_drop(int s);
    shadow_leaf[s / WORD_BITS][s % WORD_BITS] = 1'b0;
    if (shadow_leaf[s / WORD_BITS] == '0) shadow_summ[s / WORD_BITS] = 1'b0;
  endfunction

  function automatic void tree_rebuild();
    live_n = (shadow_size < N_MAX) ? shadow_size : N_MAX;
    shadow_summ = '0;
    for (int i = 0; i < LEAVES; i++) shadow_leaf[i] = '0;
    slot_mark(0);
    slot_mark(int'(live_n) + 1);
  endfunction

  // First set slot at or above s, CAP if none.
  function automatic int first_set_from(int s);
    int leaf;
    logic [WORD_BITS-1:0] w;
    logic [WORD_BITS-1:0] sm;
    leaf = s / WORD_BITS;
    w = shadow_leaf[leaf] & (WORD_ALL << (s % WORD_BITS));
    if (w != '0) return leaf * WORD_BITS + low_bit(w);
    sm = (leaf + 1 >= LEAVES) ? '0 : shadow_summ & (WORD_ALL << (leaf + 1));
    if (sm == '0) return CAP;
    leaf = low_bit(sm);
    return leaf * WORD_BITS + low_bit(shadow_leaf[leaf]);
  endfunction

  // Last set slot at or below s, CAP if none.
  function automatic int last_set_upto(int s);
    int leaf;
    logic [WORD_BITS-1:0] w;
    logic [WORD_BITS-1:0] sm;
    leaf = s / WORD_BITS;
    w = shadow_leaf[leaf] & (WORD_ALL >> (WORD_BITS - 1 - s % WORD_BITS));
    if (w != '0) return leaf * WORD_BITS + high_bit(w);
    if (leaf == 0) return CAP;
    sm = shadow_summ & (WORD_ALL >> (WORD_BITS - leaf));
    if (sm == '0) return CAP;
    leaf = high_bit(sm);
    return leaf * WORD_BITS + high_bit(shadow_leaf[leaf]);
  endfunction

  function automatic set_answer_t predict_set_op(mode_t m, logic [11:0] idx);
    set_answer_t a;
    int s;
    int slot;
    a = '0;
    slot = int'(idx) + 1;
    case (m)
      MODE_INSERT: begin
        if (idx < live_n && !shadow_leaf[slot / WORD_BITS][slot % WORD_BITS]) begin
          slot_mark(slot);
          a.found = 1'b1;
        end
      end
      MODE_ERASE: begin
        if (idx < live_n && shadow_leaf[slot / WORD_BITS][slot % WORD_BITS]) begin
          slot_drop(slot);
          a.found = 1'b1;
        end
      end
      MODE_CONTAINS: begin
        if (idx < live_n) a.found = shadow_leaf[slot / WORD_BITS][slot % WORD_BITS];
      end
      MODE_NEXT: begin
        a.pos = live_n;
        if (idx <= live_n) begin
          s = first_set_from(slot);
          if (s >= 1 && s <= int'(live_n)) begin
            a.pos = 12'(s - 1);
            a.found = 1'b1;
          end
        end
      end
      MODE_PREV: begin
        a.pos = live_n;
        if (idx < live_n) begin
          s = last_set_upto(slot);
          if (s >= 1 && s <= int'(live_n)) begin
            a.pos = 12'(s - 1);
            a.found = 1'b1;
          end
        end
      end
      MODE_CLEAR: tree_rebuild();
      default: ;
    endcase
    return a;
  endfunction

  // Present one beat, hold until accepted, then log the expected answer.
  task automatic send_op(mode_t m, logic [11:0] idx, logic typed, set_answer_t typed_ans);
    set_answer_t a;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, idx, m};
    do @(posedge clk); while (!in_tready);
    a = predict_set_op(m, idx);
    pending_answers.insert(pending_answers.size(), typed ? typed_ans : a);
    ops_sent++;
  endtask

  task automatic idle_tx(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [11:0] v);
    idle_tx(1);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    shadow_size = v;
    size_count++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [11:0] below_n(int n);
    if (n <= 0) return 12'd0;
    return 12'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [11:0] pick_index(int n, int centre);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return below_n(n);
      4, 5: begin
        if (n <= 0) return 12'd0;
        return 12'((centre + $urandom_range(0, 140) - 70 + 2 * n) % n);
      end
      6, 7: begin
        case ($urandom_range(0, 5))
          0: return 12'd0;
          1: return 12'(n - 1);
          2: return 12'(n);
          3: return 12'(n + 1);
          4: return {6'($urandom_range(0, 63)), 6'd0} - 12'($urandom_range(1, 3));
          default: return 12'hFFF;
        endcase
      end
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return MODE_INSERT;
    if (r < 45) return MODE_ERASE;
    if (r < 60) return MODE_CONTAINS;
    if (r < 78) return MODE_NEXT;
    if (r < 96) return MODE_PREV;
    if (r < 98) return MODE_CLEAR;
    return (r == 98) ? MODE_SPARE6 : MODE_SPARE7;
  endfunction

  // Receiver: random back-pressure bursts, plus one long hold on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        $error("unexpected result beat: found=%0b position=%0d", out_tdata[0], out_tdata[12:1]);
        fail_count++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (out_tdata[0] !== head_answer.found) begin
          $error("found: expected %0b, got %0b", head_answer.found, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[12:1] !== head_answer.pos) begin
          $error("position: expected %0d, got %0d", head_answer.pos, out_tdata[12:1]);
          fail_count++;
        end
        if (out_tdata[15:13] !== 3'd0) begin
          $error("pad: expected 0, got %0d", out_tdata[15:13]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          ph;
    int          tries;
    int          useful;
    int          phase_useful;
    int          no_gap_left;
    int          centre;
    int          n;
    mode_t       m;
    logic [11:0] idx;
    logic [11:0] sz;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    shadow_size = SIZE_RESET;
    tree_rebuild();
    useful      = 0;
    no_gap_left = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_N; r++) begin
      send_op(DIR_TAB[r].mode, DIR_TAB[r].index, DIR_TAB[r].typed,
              '{DIR_TAB[r].found, DIR_TAB[r].pos});
    end

    ph = 0;
    while (ops_sent < TARGET_OPS) begin
      sz = (ph < SIZE_PLAN_N) ? 12'(SIZE_PLAN[ph]) : 12'($urandom_range(0, 4095));
      write_size(sz);
      // Leave the old size live now and then, until a clear comes along.
      if (ph == 0 || $urandom_range(0, 3) != 0)
        send_op(MODE_CLEAR, 12'($urandom_range(0, 4095)), 1'b0, '0);
      if (ph == 1) begin
        hold_pending = 1'b1;
        no_gap_left  = 40;
      end
      centre = (live_n > 0) ? $urandom_range(0, int'(live_n) - 1) : 0;
      phase_useful = 0;
      tries = 0;
      while (phase_useful < PHASE_OPS && tries < PHASE_TRY && ops_sent < TARGET_OPS) begin
        if (ops_sent >= QUIET_OPS) begin
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
        end
        n   = int'(live_n);
        m   = pick_mode();
        idx = pick_index(n, centre);
        if (m == MODE_CLEAR || (m <= MODE_PREV && (int'(idx) < n ||
            (m == MODE_NEXT && int'(idx) == n))))
          phase_useful++;
        if (no_gap_left > 0) no_gap_left--;
        else if (tx_idle_on && $urandom_range(0, 5) == 0) idle_tx($urandom_range(1, 9));
        send_op(m, idx, 1'b0, '0);
        tries++;
      end
      useful += phase_useful;
      ph++;
    end

    idle_tx(1);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("summary: %0d operations (%0d random in range) over %0d size settings,",
             ops_sent, useful, size_count);
    $display("summary: %0d results checked, %0d mismatches, %0d answers left outstanding",
             results_seen, fail_count, pending_answers.size());
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/hbs_pkg.sv
design/hbs_scan.sv
design/hierarchical_bitset_successor.sv
test/tb_hierarchical_bitset_successor.sv
